### sv/ffra_pkg.sv
// shared constants for the first-fit region allocator
package ffra_pkg;

   localparam int MaxSegmentsDefault       = 16;
   localparam int BlockHeaderBytesDefault  = 24;
   localparam int RegionHeaderBytesDefault = 16;

   localparam int DataW  = 32;
   localparam int AlignW = 16;

   localparam logic [DataW-1:0]  RegionSizeReset = 32'd65536;
   localparam logic [AlignW-1:0] AlignMaskReset  = 16'd63;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_NO_SPACE = 2'd1,
      ST_FULL     = 2'd2
   } status_type;

   typedef enum logic [0:0] {
      CSR_REGION_SIZE = 1'b0,
      CSR_ALIGN_MASK  = 1'b1
   } csr_index_type;

   typedef enum logic [0:0] {
      REQ_ALLOC = 1'b0,
      REQ_FREE  = 1'b1
   } req_kind_type;

endpackage

### sv/ffra_ram.sv
// generic simple dual-port ram with registered read
module ffra_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/first_fit_region_allocator_core.sv
// first-fit region allocator core with segment table in ram
//
//  channel | direction | handshake          | payload
//  req     | in        | req_valid/req_stall | req_type, req_size, req_block_offset, req_block_size
//  rsp     | out       | rsp_valid/rsp_stall | rsp_status, rsp_result_offset, rsp_granted_size
//  csr     | in        | csr_valid/csr_ready | csr_index, csr_data
//
//  each table entry scanned passes S_SCAN_RD and S_SCAN_EV, and each entry shifted passes
//  a read state and a write state, set by the single read port of the segment ram
//  reset and each register write rebuild the table in state S_REBUILD; no item is taken then
//  one item is worked at a time; a finished result waits in the output register
//  rsp_stall holds the output register; the next item is still taken, but its result waits in S_DONE
module first_fit_region_allocator_core #(
   parameter int MAX_SEGMENTS        = ffra_pkg::MaxSegmentsDefault,
   parameter int BLOCK_HEADER_BYTES  = ffra_pkg::BlockHeaderBytesDefault,
   parameter int REGION_HEADER_BYTES = ffra_pkg::RegionHeaderBytesDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_type,
   input  logic [31:0] req_size,
   input  logic [31:0] req_block_offset,
   input  logic [31:0] req_block_size,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_result_offset,
   output logic [31:0] rsp_granted_size,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [31:0] csr_data
);

   localparam int AW = $clog2(MAX_SEGMENTS);
   localparam int CW = $clog2(MAX_SEGMENTS + 1);
   localparam logic [CW-1:0] MaxCount = CW'(MAX_SEGMENTS);
   localparam logic [31:0] Bh = 32'(BLOCK_HEADER_BYTES);
   localparam logic [17:0] Rh18 = 18'(REGION_HEADER_BYTES);
   localparam logic [17:0] Bh18 = 18'(BLOCK_HEADER_BYTES);

   typedef enum logic [9:0] {
      S_REBUILD = 10'b0000000001,
      S_IDLE    = 10'b0000000010,
      S_SCAN_RD = 10'b0000000100,
      S_SCAN_EV = 10'b0000001000,
      S_NEXT_EV = 10'b0000010000,
      S_RM_RD   = 10'b0000100000,
      S_RM_WR   = 10'b0001000000,
      S_INS_RD  = 10'b0010000000,
      S_INS_WR  = 10'b0100000000,
      S_DONE    = 10'b1000000000
   } state_type;

   state_type        state_ff, state_in;
   logic [31:0]      region_ff, region_in;
   logic [15:0]      align_ff, align_in;
   logic [CW-1:0]    count_ff, count_in;
   logic [CW-1:0]    idx_ff, idx_in;
   logic [CW-1:0]    kidx_ff, kidx_in;
   logic             kind_ff, kind_in;
   logic [31:0]      sz_ff, sz_in;
   logic [31:0]      boff_ff, boff_in;
   logic [31:0]      bsz_ff, bsz_in;
   logic [31:0]      seg_s_ff, seg_s_in;
   logic [32:0]      nl_ff, nl_in;
   logic [1:0]       st_ff, st_in;
   logic [31:0]      off_ff, off_in;
   logic [31:0]      gsz_ff, gsz_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [1:0]       rsp_status_ff, rsp_status_in;
   logic [31:0]      rsp_off_ff, rsp_off_in;
   logic [31:0]      rsp_gsz_ff, rsp_gsz_in;

   logic             wr_en;
   logic [AW-1:0]    wr_addr;
   logic [63:0]      wr_data;
   logic [AW-1:0]    rd_addr;
   logic [63:0]      rd_data;

   logic             req_acc, csr_acc, rsp_free;
   logic [31:0]      rs, rl, cur;
   logic [32:0]      cend, send, sum33, sz_bh, nl_free_lo, nl_free_hi;
   logic [33:0]      aligned34, nl_end, ml;
   logic [17:0]      hs, bs, m18;
   logic [32:0]      m33;

   ffra_ram #(.WIDTH(64), .DEPTH(MAX_SEGMENTS)) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_stall = (state_ff != S_IDLE) || csr_valid;
   assign csr_ready = (state_ff == S_IDLE);
   assign req_acc   = req_valid && !req_stall;
   assign csr_acc   = csr_valid && csr_ready;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   assign rs = rd_data[63:32];
   assign rl = rd_data[31:0];
   assign m18 = {2'b00, align_ff};
   assign m33 = {17'd0, align_ff};
   assign hs = (Rh18 + m18) & ~m18;
   assign bs = (Bh18 + m18) & ~m18;
   assign sum33 = {1'b0, req_size} + {1'b0, Bh};
   assign aligned34 = ({1'b0, sum33} + {1'b0, m33}) & ~{1'b0, m33};
   assign cur = boff_ff - Bh;
   assign cend = {1'b0, cur} + {1'b0, bsz_ff};
   assign send = {1'b0, rs} + {1'b0, rl};
   assign sz_bh = {1'b0, sz_ff} + {1'b0, Bh};
   assign nl_free_lo = {1'b0, bsz_ff} + {1'b0, rl};
   assign nl_free_hi = {1'b0, rl} + {1'b0, bsz_ff};
   assign nl_end = {2'b00, seg_s_ff} + {1'b0, nl_ff};
   assign ml = {1'b0, nl_ff} + {2'b00, rl};

   always_comb begin
      state_in = state_ff;
      region_in = region_ff;
      align_in = align_ff;
      count_in = count_ff;
      idx_in = idx_ff;
      kidx_in = kidx_ff;
      kind_in = kind_ff;
      sz_in = sz_ff;
      boff_in = boff_ff;
      bsz_in = bsz_ff;
      seg_s_in = seg_s_ff;
      nl_in = nl_ff;
      st_in = st_ff;
      off_in = off_ff;
      gsz_in = gsz_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_off_in = rsp_off_ff;
      rsp_gsz_in = rsp_gsz_ff;
      wr_en = 1'b0;
      wr_addr = idx_ff[AW-1:0];
      wr_data = {seg_s_ff, nl_ff[31:0]};
      rd_addr = idx_ff[AW-1:0];

      unique case (state_ff)
         S_REBUILD: begin
            if ({1'b0, region_ff} < {15'd0, hs} + {15'd0, bs}) begin
               count_in = '0;
            end else begin
               wr_en = 1'b1;
               wr_addr = '0;
               wr_data = {{14'd0, hs}, region_ff - {14'd0, hs}};
               count_in = CW'(1);
            end
            state_in = S_IDLE;
         end
         S_IDLE: begin
            if (csr_acc) begin
               if (csr_index == ffra_pkg::CSR_REGION_SIZE) begin
                  region_in = csr_data;
               end else begin
                  align_in = csr_data[15:0];
               end
               state_in = S_REBUILD;
            end else if (req_acc) begin
               kind_in = req_type;
               boff_in = req_block_offset;
               bsz_in = req_block_size;
               sz_in = aligned34[31:0];
               idx_in = '0;
               off_in = '0;
               gsz_in = '0;
               if (req_type == ffra_pkg::REQ_ALLOC &&
                   (sum33[32] || aligned34[33:32] != 2'b00)) begin
                  st_in = ffra_pkg::ST_NO_SPACE;
                  state_in = S_DONE;
               end else begin
                  state_in = S_SCAN_RD;
               end
            end
         end
         S_SCAN_RD: begin
            if (idx_ff == count_ff) begin
               state_in = S_DONE;
               if (kind_ff == ffra_pkg::REQ_ALLOC) begin
                  st_in = ffra_pkg::ST_NO_SPACE;
               end else if (count_ff == MaxCount) begin
                  st_in = ffra_pkg::ST_FULL;
               end else begin
                  wr_en = 1'b1;
                  wr_addr = count_ff[AW-1:0];
                  wr_data = {cur, bsz_ff};
                  count_in = count_ff + CW'(1);
                  off_in = boff_ff;
                  gsz_in = bsz_ff;
                  st_in = ffra_pkg::ST_OK;
               end
            end else begin
               state_in = S_SCAN_EV;
            end
         end
         S_SCAN_EV: begin
            rd_addr = AW'(idx_ff + CW'(1));
            if (kind_ff == ffra_pkg::REQ_ALLOC) begin
               if (rl >= sz_ff) begin
                  st_in = ffra_pkg::ST_OK;
                  off_in = rs + Bh;
                  if ({1'b0, rl} < sz_bh) begin
                     gsz_in = rl;
                     kidx_in = idx_ff;
                     state_in = S_RM_RD;
                  end else begin
                     wr_en = 1'b1;
                     wr_data = {rs + sz_ff, rl - sz_ff};
                     gsz_in = sz_ff;
                     state_in = S_DONE;
                  end
               end else begin
                  idx_in = idx_ff + CW'(1);
                  state_in = S_SCAN_RD;
               end
            end else begin
               off_in = boff_ff;
               gsz_in = bsz_ff;
               if (cur < rs) begin
                  if (cend == {1'b0, rs}) begin
                     state_in = S_DONE;
                     if (nl_free_lo[32]) begin
                        st_in = ffra_pkg::ST_NO_SPACE;
                     end else begin
                        wr_en = 1'b1;
                        wr_data = {cur, nl_free_lo[31:0]};
                        st_in = ffra_pkg::ST_OK;
                     end
                  end else if (count_ff == MaxCount) begin
                     st_in = ffra_pkg::ST_FULL;
                     state_in = S_DONE;
                  end else begin
                     kidx_in = count_ff;
                     state_in = S_INS_RD;
                  end
               end else if (send == {1'b0, cur}) begin
                  if (nl_free_hi[32]) begin
                     st_in = ffra_pkg::ST_NO_SPACE;
                     state_in = S_DONE;
                  end else if (idx_ff + CW'(1) < count_ff) begin
                     seg_s_in = rs;
                     nl_in = nl_free_hi;
                     state_in = S_NEXT_EV;
                  end else begin
                     wr_en = 1'b1;
                     wr_data = {rs, nl_free_hi[31:0]};
                     st_in = ffra_pkg::ST_OK;
                     state_in = S_DONE;
                  end
               end else begin
                  idx_in = idx_ff + CW'(1);
                  state_in = S_SCAN_RD;
               end
            end
         end
         S_NEXT_EV: begin
            if (nl_end == {2'b00, rs}) begin
               if (ml[33:32] != 2'b00) begin
                  st_in = ffra_pkg::ST_NO_SPACE;
                  state_in = S_DONE;
               end else begin
                  wr_en = 1'b1;
                  wr_data = {seg_s_ff, ml[31:0]};
                  st_in = ffra_pkg::ST_OK;
                  kidx_in = idx_ff + CW'(1);
                  state_in = S_RM_RD;
               end
            end else begin
               wr_en = 1'b1;
               wr_data = {seg_s_ff, nl_ff[31:0]};
               st_in = ffra_pkg::ST_OK;
               state_in = S_DONE;
            end
         end
         S_RM_RD: begin
            rd_addr = AW'(kidx_ff + CW'(1));
            if (kidx_ff + CW'(1) < count_ff) begin
               state_in = S_RM_WR;
            end else begin
               count_in = count_ff - CW'(1);
               state_in = S_DONE;
            end
         end
         S_RM_WR: begin
            wr_en = 1'b1;
            wr_addr = kidx_ff[AW-1:0];
            wr_data = rd_data;
            kidx_in = kidx_ff + CW'(1);
            state_in = S_RM_RD;
         end
         S_INS_RD: begin
            rd_addr = AW'(kidx_ff - CW'(1));
            if (kidx_ff > idx_ff) begin
               state_in = S_INS_WR;
            end else begin
               wr_en = 1'b1;
               wr_data = {cur, bsz_ff};
               count_in = count_ff + CW'(1);
               st_in = ffra_pkg::ST_OK;
               state_in = S_DONE;
            end
         end
         S_INS_WR: begin
            wr_en = 1'b1;
            wr_addr = kidx_ff[AW-1:0];
            wr_data = rd_data;
            kidx_in = kidx_ff - CW'(1);
            state_in = S_INS_RD;
         end
         S_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_status_in = st_ff;
               rsp_off_in = (st_ff == ffra_pkg::ST_OK) ? off_ff : '0;
               rsp_gsz_in = (st_ff == ffra_pkg::ST_OK) ? gsz_ff : '0;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_REBUILD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_REBUILD;
         region_ff <= ffra_pkg::RegionSizeReset;
         align_ff <= ffra_pkg::AlignMaskReset;
         count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         region_ff <= region_in;
         align_ff <= align_in;
         count_ff <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      kidx_ff <= kidx_in;
      kind_ff <= kind_in;
      sz_ff <= sz_in;
      boff_ff <= boff_in;
      bsz_ff <= bsz_in;
      seg_s_ff <= seg_s_in;
      nl_ff <= nl_in;
      st_ff <= st_in;
      off_ff <= off_in;
      gsz_ff <= gsz_in;
      rsp_status_ff <= rsp_status_in;
      rsp_off_ff <= rsp_off_in;
      rsp_gsz_ff <= rsp_gsz_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_result_offset = rsp_off_ff;
   assign rsp_granted_size = rsp_gsz_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= MaxCount)
      else $error("segment count above table depth");
   a_req_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> state_ff != S_IDLE)
      else $error("item accepted without starting work");
   a_csr_rebuild: assert property (@(posedge clock) disable iff (reset)
      csr_acc |=> state_ff == S_REBUILD)
      else $error("register write did not rebuild table");
   a_rebuild_one_cycle: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_REBUILD |=> state_ff == S_IDLE)
      else $error("rebuild took more than one cycle");
`endif

endmodule
